[src/dmru_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package dmru_pkg;

    localparam int LIST_DEPTH = 16;
    localparam int ID_BITS    = 16;
    localparam int IDX_BITS   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int COUNT_BITS = $clog2(LIST_DEPTH + 1);
    localparam int DELAY_BITS = 13;

    localparam logic [DELAY_BITS-1:0] DEBOUNCE_MAX = DELAY_BITS'(5000);

    typedef enum logic [2:0] {
        ACT_FOCUS  = 3'd0,
        ACT_TICK   = 3'd1,
        ACT_FLUSH  = 3'd2,
        ACT_LOCK   = 3'd3,
        ACT_CLEAR  = 3'd4,
        ACT_APPEND = 3'd5,
        ACT_READ   = 3'd6
    } action_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_IGNORED   = 3'd1,
        ST_COMMITTED = 3'd2,
        ST_DROPPED   = 3'd3,
        ST_NOTHING   = 3'd4,
        ST_DUPLICATE = 3'd5,
        ST_INVALID   = 3'd6,
        ST_FULL      = 3'd7
    } status_t;

    typedef struct packed {
        logic                en;
        logic [IDX_BITS-1:0] addr;
        logic [ID_BITS-1:0]  data;
    } store_wr_t;

    // port words are 16 bits, list entries ID_BITS wide
    function automatic logic [ID_BITS-1:0] to_id(input logic [15:0] w);
        logic [47:0] wide;
        wide = 48'(w);
        return wide[ID_BITS-1:0];
    endfunction

    function automatic logic [15:0] from_id(input logic [ID_BITS-1:0] id);
        logic [47:0] wide;
        wide = 48'(id);
        return wide[15:0];
    endfunction

endpackage

`default_nettype wire

[src/dmru_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface dmru_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [15:0] window_id;
    logic        still_valid;
    logic        lock_value;
    logic [3:0]  read_index;

    modport source (
        output valid, action, window_id, still_valid, lock_value, read_index,
        input  ready
    );

    modport sink (
        input  valid, action, window_id, still_valid, lock_value, read_index,
        output ready
    );
endinterface

`default_nettype wire

[src/dmru_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface dmru_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [15:0] entry_window;
    logic        entry_present;
    logic [4:0]  list_count;
    logic        pending_flag;
    logic        locked_flag;

    modport source (
        output valid, status, entry_window, entry_present, list_count,
               pending_flag, locked_flag,
        input  ready
    );

    modport sink (
        input  valid, status, entry_window, entry_present, list_count,
               pending_flag, locked_flag,
        output ready
    );
endinterface

`default_nettype wire

[src/dmru_store.sv]
`timescale 1ns / 1ps
`default_nettype none

module dmru_store (
    input  wire logic                           clk,
    input  wire dmru_pkg::store_wr_t            wr,
    input  wire logic [dmru_pkg::IDX_BITS-1:0]  rd_addr,
    output logic      [dmru_pkg::ID_BITS-1:0]   rd_data
);

    logic [dmru_pkg::ID_BITS-1:0] mem [dmru_pkg::LIST_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[src/debounced_mru_list_tracker_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// channel  | dir | handshake     | word
// item     | in  | valid/ready   | action, window_id, still_valid, lock_value, read_index
// result   | out | valid/ready   | status, entry_window, entry_present, list_count, flags
// cfg      | in  | cfg_wen       | cfg_wdata = debounce delay in ticks, saturates at 5000
//
// One word in flight at a time; item.ready is high only while the sequencer is idle.
// Simple actions step through accept, front read and result load. A seed append adds a
// list search; a valid commit adds the search, a shift of the entries and one front write.
// A result held by a stalled sink parks the sequencer before the result load.
// rst_n clears control state; list RAM contents are not reset, and entries at or beyond the count are never used.

module debounced_mru_list_tracker_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wen,
    input  wire logic [12:0] cfg_wdata,
    dmru_in_if.sink          item,
    dmru_out_if.source       result
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_PUT,
        S_FRONT,
        S_OUT
    } state_t;

    localparam int IB = dmru_pkg::IDX_BITS;
    localparam int CB = dmru_pkg::COUNT_BITS;
    localparam int DB = dmru_pkg::DELAY_BITS;
    localparam int WB = dmru_pkg::ID_BITS;

    state_t state_reg, state_next;

    logic [DB-1:0] debounce_reg, debounce_next;
    logic [DB-1:0] delay_reg, delay_next;
    logic          pend_vld_reg, pend_vld_next;
    logic [WB-1:0] pend_win_reg, pend_win_next;
    logic          locked_reg, locked_next;
    logic [CB-1:0] count_reg, count_next;

    logic [WB-1:0] key_reg, key_next;
    logic          commit_reg, commit_next;
    logic          is_read_reg, is_read_next;
    logic [3:0]    ridx_reg, ridx_next;
    dmru_pkg::status_t status_reg, status_next;

    logic [CB-1:0] issue_reg, issue_next;
    logic          cmp_vld_reg, cmp_vld_next;
    logic [IB-1:0] cmp_idx_reg, cmp_idx_next;
    logic [IB-1:0] j_reg, j_next;
    logic [IB-1:0] dst_reg, dst_next;
    logic          shift_vld_reg, shift_vld_next;

    logic          out_vld_reg, out_vld_next;
    logic [2:0]    out_status_reg, out_status_next;
    logic [15:0]   out_entry_reg, out_entry_next;
    logic          out_present_reg, out_present_next;
    logic [4:0]    out_count_reg, out_count_next;
    logic          out_pend_reg, out_pend_next;
    logic          out_lock_reg, out_lock_next;

    dmru_pkg::store_wr_t store_wr;
    logic [IB-1:0] rd_addr;
    logic [WB-1:0] rd_data;

    logic [7:0]    ridx_w;
    logic [7:0]    count_w;
    logic [IB-1:0] front_addr;
    logic          full;
    logic          hit;
    logic          present;
    logic          do_commit;
    logic          accept;

    dmru_store u_store (
        .clk     (clk),
        .wr      (store_wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign accept     = item.valid && item.ready;
    assign ridx_w     = 8'(ridx_reg);
    assign count_w    = 8'(count_reg);
    assign front_addr = is_read_reg ? ridx_w[IB-1:0] : '0;
    assign full       = (count_reg == CB'(dmru_pkg::LIST_DEPTH));
    assign hit        = cmp_vld_reg && (rd_data == key_reg);
    assign present    = is_read_reg ? (ridx_w < count_w) : (count_reg != '0);

    assign item.ready           = (state_reg == S_IDLE);
    assign result.valid         = out_vld_reg;
    assign result.status        = out_status_reg;
    assign result.entry_window  = out_entry_reg;
    assign result.entry_present = out_present_reg;
    assign result.list_count    = out_count_reg;
    assign result.pending_flag  = out_pend_reg;
    assign result.locked_flag   = out_lock_reg;

    always_comb
    begin
        state_next       = state_reg;
        debounce_next    = debounce_reg;
        delay_next       = delay_reg;
        pend_vld_next    = pend_vld_reg;
        pend_win_next    = pend_win_reg;
        locked_next      = locked_reg;
        count_next       = count_reg;
        key_next         = key_reg;
        commit_next      = commit_reg;
        is_read_next     = is_read_reg;
        ridx_next        = ridx_reg;
        status_next      = status_reg;
        issue_next       = issue_reg;
        cmp_vld_next     = cmp_vld_reg;
        cmp_idx_next     = cmp_idx_reg;
        j_next           = j_reg;
        dst_next         = dst_reg;
        shift_vld_next   = shift_vld_reg;
        out_vld_next     = out_vld_reg && !result.ready;
        out_status_next  = out_status_reg;
        out_entry_next   = out_entry_reg;
        out_present_next = out_present_reg;
        out_count_next   = out_count_reg;
        out_pend_next    = out_pend_reg;
        out_lock_next    = out_lock_reg;
        store_wr         = '0;
        rd_addr          = front_addr;
        do_commit        = 1'b0;

        if (cfg_wen)
        begin
            debounce_next = (cfg_wdata > dmru_pkg::DEBOUNCE_MAX) ? dmru_pkg::DEBOUNCE_MAX
                                                                 : cfg_wdata;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next  = dmru_pkg::ST_OK;
                    is_read_next = (item.action == dmru_pkg::ACT_READ);
                    ridx_next    = item.read_index;
                    state_next   = S_FRONT;
                    unique case (dmru_pkg::action_t'(item.action))
                        dmru_pkg::ACT_FOCUS:
                        begin
                            if (locked_reg)
                            begin
                                status_next = dmru_pkg::ST_IGNORED;
                            end
                            else
                            begin
                                pend_vld_next = 1'b1;
                                pend_win_next = dmru_pkg::to_id(item.window_id);
                                delay_next    = debounce_reg;
                            end
                        end
                        dmru_pkg::ACT_TICK:
                        begin
                            if (pend_vld_reg)
                            begin
                                if (delay_reg <= DB'(1))
                                begin
                                    do_commit = 1'b1;
                                end
                                else
                                begin
                                    delay_next = delay_reg - DB'(1);
                                end
                            end
                        end
                        dmru_pkg::ACT_FLUSH:
                        begin
                            if (pend_vld_reg)
                            begin
                                do_commit = 1'b1;
                            end
                            else
                            begin
                                status_next = dmru_pkg::ST_NOTHING;
                            end
                        end
                        dmru_pkg::ACT_LOCK:
                        begin
                            if (item.lock_value && !locked_reg)
                            begin
                                pend_vld_next = 1'b0;
                                pend_win_next = '0;
                                delay_next    = '0;
                            end
                            locked_next = item.lock_value;
                        end
                        dmru_pkg::ACT_CLEAR:
                        begin
                            count_next = '0;
                        end
                        dmru_pkg::ACT_APPEND:
                        begin
                            if (!item.still_valid)
                            begin
                                status_next = dmru_pkg::ST_INVALID;
                            end
                            else
                            begin
                                key_next     = dmru_pkg::to_id(item.window_id);
                                commit_next  = 1'b0;
                                issue_next   = '0;
                                cmp_vld_next = 1'b0;
                                state_next   = S_SEARCH;
                            end
                        end
                        default:
                        begin
                        end
                    endcase

                    if (do_commit)
                    begin
                        pend_vld_next = 1'b0;
                        pend_win_next = '0;
                        delay_next    = '0;
                        if (!item.still_valid)
                        begin
                            status_next = dmru_pkg::ST_DROPPED;
                        end
                        else
                        begin
                            status_next  = dmru_pkg::ST_COMMITTED;
                            key_next     = pend_win_reg;
                            commit_next  = 1'b1;
                            issue_next   = '0;
                            cmp_vld_next = 1'b0;
                            state_next   = S_SEARCH;
                        end
                    end
                end
            end

            S_SEARCH:
            begin
                // one read issued per cycle, compared against the key in the cycle after
                rd_addr = issue_reg[IB-1:0];
                if (!hit && (issue_reg < count_reg))
                begin
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = issue_reg[IB-1:0];
                    issue_next   = issue_reg + CB'(1);
                end
                else
                begin
                    cmp_vld_next = 1'b0;
                    if (commit_reg)
                    begin
                        shift_vld_next = 1'b0;
                        state_next     = S_SHIFT;
                        if (hit)
                        begin
                            j_next = cmp_idx_reg;
                        end
                        else if (full)
                        begin
                            j_next = IB'(dmru_pkg::LIST_DEPTH - 1);
                        end
                        else
                        begin
                            j_next     = count_reg[IB-1:0];
                            count_next = count_reg + CB'(1);
                        end
                    end
                    else
                    begin
                        state_next = S_FRONT;
                        if (hit)
                        begin
                            status_next = dmru_pkg::ST_DUPLICATE;
                        end
                        else if (full)
                        begin
                            status_next = dmru_pkg::ST_FULL;
                        end
                        else
                        begin
                            store_wr.en   = 1'b1;
                            store_wr.addr = count_reg[IB-1:0];
                            store_wr.data = key_reg;
                            count_next    = count_reg + CB'(1);
                        end
                    end
                end
            end

            S_SHIFT:
            begin
                // move entries down by one, from the back toward the front
                rd_addr = j_reg - IB'(1);
                if (shift_vld_reg)
                begin
                    store_wr.en   = 1'b1;
                    store_wr.addr = dst_reg;
                    store_wr.data = rd_data;
                end
                if (j_reg != '0)
                begin
                    shift_vld_next = 1'b1;
                    dst_next       = j_reg;
                    j_next         = j_reg - IB'(1);
                end
                else
                begin
                    shift_vld_next = 1'b0;
                    if (!shift_vld_reg)
                    begin
                        state_next = S_PUT;
                    end
                end
            end

            S_PUT:
            begin
                store_wr.en   = 1'b1;
                store_wr.addr = '0;
                store_wr.data = key_reg;
                state_next    = S_FRONT;
            end

            S_FRONT:
            begin
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (!out_vld_reg || result.ready)
                begin
                    out_vld_next     = 1'b1;
                    out_status_next  = status_reg;
                    out_entry_next   = present ? dmru_pkg::from_id(rd_data) : 16'd0;
                    out_present_next = present;
                    out_count_next   = count_w[4:0];
                    out_pend_next    = pend_vld_reg;
                    out_lock_next    = locked_reg;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            debounce_reg    <= '0;
            delay_reg       <= '0;
            pend_vld_reg    <= 1'b0;
            pend_win_reg    <= '0;
            locked_reg      <= 1'b0;
            count_reg       <= '0;
            key_reg         <= '0;
            commit_reg      <= 1'b0;
            is_read_reg     <= 1'b0;
            ridx_reg        <= '0;
            status_reg      <= dmru_pkg::ST_OK;
            issue_reg       <= '0;
            cmp_vld_reg     <= 1'b0;
            cmp_idx_reg     <= '0;
            j_reg           <= '0;
            dst_reg         <= '0;
            shift_vld_reg   <= 1'b0;
            out_vld_reg     <= 1'b0;
            out_status_reg  <= '0;
            out_entry_reg   <= '0;
            out_present_reg <= 1'b0;
            out_count_reg   <= '0;
            out_pend_reg    <= 1'b0;
            out_lock_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            debounce_reg    <= debounce_next;
            delay_reg       <= delay_next;
            pend_vld_reg    <= pend_vld_next;
            pend_win_reg    <= pend_win_next;
            locked_reg      <= locked_next;
            count_reg       <= count_next;
            key_reg         <= key_next;
            commit_reg      <= commit_next;
            is_read_reg     <= is_read_next;
            ridx_reg        <= ridx_next;
            status_reg      <= status_next;
            issue_reg       <= issue_next;
            cmp_vld_reg     <= cmp_vld_next;
            cmp_idx_reg     <= cmp_idx_next;
            j_reg           <= j_next;
            dst_reg         <= dst_next;
            shift_vld_reg   <= shift_vld_next;
            out_vld_reg     <= out_vld_next;
            out_status_reg  <= out_status_next;
            out_entry_reg   <= out_entry_next;
            out_present_reg <= out_present_next;
            out_count_reg   <= out_count_next;
            out_pend_reg    <= out_pend_next;
            out_lock_reg    <= out_lock_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CB'(dmru_pkg::LIST_DEPTH))
        else $error("list count above depth");

    a_lock_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        locked_reg |-> !pend_vld_reg)
        else $error("commit pending while locked");

    a_idle_delay: assert property (@(posedge clk) disable iff (!rst_n)
        !pend_vld_reg |-> (delay_reg == '0))
        else $error("countdown running with nothing pending");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("accepted word not processed");

    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        store_wr.en |-> (state_reg != S_IDLE) && !item.ready)
        else $error("list write while idle");

endmodule

`default_nettype wire
